FILE: rtl/core/bpc_pkg.sv
package bpc_pkg;

    // Field and calibration word widths.
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int CAL_IDX_W  = 3;
    localparam int PRES_W     = 32;
    localparam int TEMP_OUT_W = 19;

    // Pipeline depth, input register through output register.
    localparam int NUM_STAGES = 11;

    // Compensated temperature limits in hundredths of a degree.
    localparam logic signed [TEMP_OUT_W-1:0] TEMP_HI = 19'sd140000;
    localparam logic signed [TEMP_OUT_W-1:0] TEMP_LO = -19'sd140000;

    // Calibration register indexes.
    typedef enum logic [CAL_IDX_W-1:0] {
        CAL_SENS     = 3'd0,
        CAL_OFF      = 3'd1,
        CAL_TCS      = 3'd2,
        CAL_TCO      = 3'd3,
        CAL_TREF     = 3'd4,
        CAL_TEMPSENS = 3'd5
    } cal_idx_t;

endpackage

FILE: rtl/core/baro_pressure_compensation_unit.sv
// Throughput: one item per cycle while m_ready is high; in the eleven-stage multiplier
// pipeline each stage holds its item while the next stage is full and cannot move
// on, so no item is lost while the output is stalled.
// Reset (aresetn low at a clock edge) clears every stage valid bit and all six
// calibration words; stage data registers are not reset.
module baro_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CAL_IDX_W-1:0]          cfg_index,
    input  logic [CAL_W-1:0]              cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [RAW_W-1:0]              s_raw_pressure,
    input  logic [RAW_W-1:0]              s_raw_temperature,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [PRES_W-1:0]      m_pressure,
    output logic signed [TEMP_OUT_W-1:0]  m_temperature
);

    // Calibration words.
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cal_idx_t'(cfg_index))
                CAL_SENS:     c1_reg <= cfg_wr_data;
                CAL_OFF:      c2_reg <= cfg_wr_data;
                CAL_TCS:      c3_reg <= cfg_wr_data;
                CAL_TCO:      c4_reg <= cfg_wr_data;
                CAL_TREF:     c5_reg <= cfg_wr_data;
                CAL_TEMPSENS: c6_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Stage control: a stage loads when it is empty or the next one moves on.
    logic [NUM_STAGES-1:0] valid_reg, valid_next, stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // Stage 0: temperature difference dT.
    logic [RAW_W-1:0]   d1_s0_reg;
    logic signed [24:0] dt_s0_reg, dt_s0_next;

    assign dt_s0_next = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, c5_reg, 8'd0});

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            d1_s0_reg <= s_raw_pressure;
            dt_s0_reg <= dt_s0_next;
        end
    end

    // Stage 1: the four products of dT.
    logic [RAW_W-1:0]   d1_s1_reg;
    logic signed [40:0] p6_s1_reg, p6_s1_next;
    logic signed [40:0] p4_s1_reg, p4_s1_next;
    logic signed [40:0] p3_s1_reg, p3_s1_next;
    logic signed [49:0] dd_full;
    logic [17:0]        t2_s1_reg, t2_s1_next;

    always_comb begin
        p6_s1_next = dt_s0_reg * $signed({1'b0, c6_reg});
        p4_s1_next = dt_s0_reg * $signed({1'b0, c4_reg});
        p3_s1_next = dt_s0_reg * $signed({1'b0, c3_reg});
        dd_full    = dt_s0_reg * dt_s0_reg;
        t2_s1_next = dd_full[48:31];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            d1_s1_reg <= d1_s0_reg;
            p6_s1_reg <= p6_s1_next;
            p4_s1_reg <= p4_s1_next;
            p3_s1_reg <= p3_s1_next;
            t2_s1_reg <= t2_s1_next;
        end
    end

    // Stage 2: first-order TEMP, OFF and SENS; divisions truncate toward zero.
    logic [RAW_W-1:0]   d1_s2_reg;
    logic [17:0]        t2_s2_reg;
    logic signed [40:0] p6_bias, p4_bias, p3_bias, p6_q, p4_q, p3_q;
    logic signed [19:0] temp1_s2_reg, temp1_s2_next;
    logic signed [39:0] off1_s2_reg, off1_s2_next;
    logic signed [39:0] sens1_s2_reg, sens1_s2_next;

    always_comb begin
        p6_bias       = p6_s1_reg + (p6_s1_reg[40] ? 41'sd8388607 : 41'sd0);
        p4_bias       = p4_s1_reg + (p4_s1_reg[40] ? 41'sd63 : 41'sd0);
        p3_bias       = p3_s1_reg + (p3_s1_reg[40] ? 41'sd127 : 41'sd0);
        p6_q          = p6_bias >>> 23;
        p4_q          = p4_bias >>> 6;
        p3_q          = p3_bias >>> 7;
        temp1_s2_next = 20'(p6_q) + 20'sd2000;
        off1_s2_next  = 40'(p4_q) + 40'($signed({1'b0, c2_reg, 17'd0}));
        sens1_s2_next = 40'(p3_q) + 40'($signed({1'b0, c1_reg, 16'd0}));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            d1_s2_reg    <= d1_s1_reg;
            t2_s2_reg    <= t2_s1_reg;
            temp1_s2_reg <= temp1_s2_next;
            off1_s2_reg  <= off1_s2_next;
            sens1_s2_reg <= sens1_s2_next;
        end
    end

    // Stage 3: squares for the low-temperature terms, final temperature.
    logic [RAW_W-1:0]             d1_s3_reg;
    logic signed [39:0]           off1_s3_reg, sens1_s3_reg;
    logic signed [19:0]           w_val, v_val, temp_corr;
    logic signed [39:0]           sq_full, sq2_full;
    logic [35:0]                  sq_s3_reg, sq_s3_next, sq2_s3_reg, sq2_s3_next;
    logic                         lo_s3_reg, lo_s3_next, vlo_s3_reg, vlo_s3_next;
    logic signed [TEMP_OUT_W-1:0] temp_s3_reg, temp_s3_next;

    always_comb begin
        w_val       = temp1_s2_reg - 20'sd2000;
        v_val       = temp1_s2_reg + 20'sd1500;
        sq_full     = w_val * w_val;
        sq2_full    = v_val * v_val;
        sq_s3_next  = sq_full[35:0];
        sq2_s3_next = sq2_full[35:0];
        lo_s3_next  = temp1_s2_reg < 20'sd2000;
        vlo_s3_next = temp1_s2_reg < -20'sd1500;
        temp_corr   = lo_s3_next ? temp1_s2_reg - $signed({2'b00, t2_s2_reg}) : temp1_s2_reg;
        if (temp_corr > 20'(TEMP_HI)) begin
            temp_s3_next = TEMP_HI;
        end else if (temp_corr < 20'(TEMP_LO)) begin
            temp_s3_next = TEMP_LO;
        end else begin
            temp_s3_next = 19'(temp_corr);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            d1_s3_reg    <= d1_s2_reg;
            off1_s3_reg  <= off1_s2_reg;
            sens1_s3_reg <= sens1_s2_reg;
            sq_s3_reg    <= sq_s3_next;
            sq2_s3_reg   <= sq2_s3_next;
            lo_s3_reg    <= lo_s3_next;
            vlo_s3_reg   <= vlo_s3_next;
            temp_s3_reg  <= temp_s3_next;
        end
    end

    // Stage 4: second-order offset and sensitivity corrections.
    logic [RAW_W-1:0]             d1_s4_reg;
    logic signed [39:0]           off1_s4_reg, sens1_s4_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s4_reg;
    logic [38:0]                  sq_x5, sq2_x7;
    logic [39:0]                  sq2_x11;
    logic [39:0]                  off2_s4_reg, off2_s4_next, sens2_s4_reg, sens2_s4_next;

    always_comb begin
        sq_x5   = 39'({sq_s3_reg, 2'b00}) + 39'(sq_s3_reg);
        sq2_x7  = {sq2_s3_reg, 3'b000} - 39'(sq2_s3_reg);
        sq2_x11 = 40'({sq2_s3_reg, 3'b000}) + 40'({sq2_s3_reg, 1'b0}) + 40'(sq2_s3_reg);
        if (lo_s3_reg) begin
            off2_s4_next  = 40'(sq_x5[38:1]) + (vlo_s3_reg ? 40'(sq2_x7) : 40'd0);
            sens2_s4_next = 40'(sq_x5[38:2]) + (vlo_s3_reg ? 40'(sq2_x11[39:1]) : 40'd0);
        end else begin
            off2_s4_next  = '0;
            sens2_s4_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            d1_s4_reg    <= d1_s3_reg;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            temp_s4_reg  <= temp_s3_reg;
            off2_s4_reg  <= off2_s4_next;
            sens2_s4_reg <= sens2_s4_next;
        end
    end

    // Stage 5: corrected OFF and SENS.
    logic [RAW_W-1:0]             d1_s5_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s5_reg;
    logic signed [39:0]           off_s5_reg, off_s5_next, sens_s5_reg, sens_s5_next;

    assign off_s5_next  = off1_s4_reg - $signed(off2_s4_reg);
    assign sens_s5_next = sens1_s4_reg - $signed(sens2_s4_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            d1_s5_reg   <= d1_s4_reg;
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s5_next;
            sens_s5_reg <= sens_s5_next;
        end
    end

    // Stage 6: D1 * SENS as two partial products over the halves of SENS.
    logic signed [TEMP_OUT_W-1:0] temp_s6_reg;
    logic signed [39:0]           off_s6_reg;
    logic [43:0]                  plo_s6_reg, plo_s6_next;
    logic signed [44:0]           phi_s6_reg, phi_s6_next;

    assign plo_s6_next = d1_s5_reg * sens_s5_reg[19:0];
    assign phi_s6_next = $signed({1'b0, d1_s5_reg}) * $signed(sens_s5_reg[39:20]);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            temp_s6_reg <= temp_s5_reg;
            off_s6_reg  <= off_s5_reg;
            plo_s6_reg  <= plo_s6_next;
            phi_s6_reg  <= phi_s6_next;
        end
    end

    // Stage 7: sum the partial products.
    logic signed [TEMP_OUT_W-1:0] temp_s7_reg;
    logic signed [39:0]           off_s7_reg;
    logic signed [63:0]           prod_s7_reg, prod_s7_next;

    assign prod_s7_next = (64'(phi_s6_reg) <<< 20) + $signed({20'd0, plo_s6_reg});

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            temp_s7_reg <= temp_s6_reg;
            off_s7_reg  <= off_s6_reg;
            prod_s7_reg <= prod_s7_next;
        end
    end

    // Stage 8: divide the product by 2^21, truncating toward zero.
    logic signed [TEMP_OUT_W-1:0] temp_s8_reg;
    logic signed [39:0]           off_s8_reg;
    logic signed [63:0]           prod_bias, prod_q;
    logic signed [42:0]           q_s8_reg, q_s8_next;

    always_comb begin
        prod_bias = prod_s7_reg + (prod_s7_reg[63] ? 64'sd2097151 : 64'sd0);
        prod_q    = prod_bias >>> 21;
        q_s8_next = 43'(prod_q);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            temp_s8_reg <= temp_s7_reg;
            off_s8_reg  <= off_s7_reg;
            q_s8_reg    <= q_s8_next;
        end
    end

    // Stage 9: subtract the offset.
    logic signed [TEMP_OUT_W-1:0] temp_s9_reg;
    logic signed [43:0]           r_s9_reg, r_s9_next;

    assign r_s9_next = 44'(q_s8_reg) - 44'(off_s8_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[9]) begin
            temp_s9_reg <= temp_s8_reg;
            r_s9_reg    <= r_s9_next;
        end
    end

    // Stage 10: divide by 2^15 toward zero and saturate into the output register.
    logic signed [43:0]           r_bias, r_q;
    logic signed [PRES_W-1:0]     pres_out_reg, pres_out_next;
    logic signed [TEMP_OUT_W-1:0] temp_out_reg;

    always_comb begin
        r_bias = r_s9_reg + (r_s9_reg[43] ? 44'sd32767 : 44'sd0);
        r_q    = r_bias >>> 15;
        if (r_q > 44'sd2147483647) begin
            pres_out_next = 32'sh7FFF_FFFF;
        end else if (r_q < -44'sd2147483648) begin
            pres_out_next = 32'sh8000_0000;
        end else begin
            pres_out_next = 32'(r_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[10]) begin
            pres_out_reg <= pres_out_next;
            temp_out_reg <= temp_s9_reg;
        end
    end

    assign m_pressure    = pres_out_reg;
    assign m_temperature = temp_out_reg;

endmodule

FILE: rtl/core/bpc_checker.sv
module bpc_checker
    import bpc_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [PRES_W-1:0]     m_pressure,
    input logic signed [TEMP_OUT_W-1:0] m_temperature
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure) && $stable(m_temperature))
        else $error("result item changed or dropped while stalled");

    // The pipeline only pushes back when the output holds an item that is not taken.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled although the output can move");

    // The compensated temperature stays within its clamp range.
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature <= TEMP_HI) && (m_temperature >= TEMP_LO))
        else $error("temperature outside its clamp range");

    // No result appears in the cycle after a reset.
    a_reset_empty: assert property (@(posedge aclk)
        $fell(aresetn) |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind baro_pressure_compensation_unit bpc_checker u_bpc_checker (.*);
